>>> rtl/fsa_pkg.sv
// shared types and constants for the first-fit segment allocator
// no dependencies; used by every rtl file of the block
package fsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int ID_BITS_DEF      = 16;

  localparam int IDW    = 16;  // owner id field
  localparam int BASEW  = 16;  // segment start field
  localparam int LENW   = 17;  // byte counts
  localparam int CNTOW  = 6;   // hole / owner count fields

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int RES_W      = 65;

  localparam logic [LENW-1:0] MEM_BYTES_RST = 17'd1024;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_EXISTS  = 3'd3,
    ST_FRAG    = 3'd4,
    ST_ABSENT  = 3'd5,
    ST_FULL    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDW-1:0]   id;
    logic [LENW-1:0]  size;
  } req_t;

  typedef struct packed {
    logic [IDW-1:0]   owner;
    logic [LENW-1:0]  len;
    logic [BASEW-1:0] base;
    logic             is_free;
  } seg_t;

  // packed with status in the lowest bits
  typedef struct packed {
    logic [CNTOW-1:0] owners;
    logic [CNTOW-1:0] holes;
    logic [LENW-1:0]  used;
    logic [LENW-1:0]  free;
    logic [BASEW-1:0] start;
    status_t          status;
  } res_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_SCAN,
    B_DECIDE,
    B_SHIFT,
    B_FIX1,
    B_FIX2,
    B_DONE
  } bstate_t;

endpackage

>>> rtl/fsa_queue.sv
// two-entry request queue between front and back
// depends on fsa_pkg (req_t)
module fsa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fsa_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output fsa_pkg::req_t pop_data
);

  fsa_pkg::req_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/fsa_front.sv
// request intake: unpacks the input transfer and classifies it
// depends on fsa_pkg (req_t, kind_t)
module fsa_front #(
  parameter int ID_BITS = fsa_pkg::ID_BITS_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fsa_pkg::IN_DATA_W-1:0]  in_tdata,   // owner_id, req_size
  input  logic                           in_tuser,   // req_type
  input  logic                           q_full,
  output logic                           push,
  output fsa_pkg::req_t                  push_data
);

  localparam logic [fsa_pkg::IDW-1:0] ID_MASK = (ID_BITS >= fsa_pkg::IDW) ?
    {fsa_pkg::IDW{1'b1}} : fsa_pkg::IDW'((64'd1 << ID_BITS) - 64'd1);

  logic [fsa_pkg::IDW-1:0]  id;
  logic [fsa_pkg::LENW-1:0] size;

  assign id        = in_tdata[15:0] & ID_MASK;
  assign size      = in_tdata[32:16];
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_data.id   = id;
    push_data.size = size;
    if (in_tuser) begin
      push_data.kind = fsa_pkg::KIND_FREE;
    end else if (size == '0) begin
      push_data.kind = fsa_pkg::KIND_ZERO;
    end else begin
      push_data.kind = fsa_pkg::KIND_ALLOC;
    end
  end

endmodule

>>> rtl/fsa_back.sv
// table engine: scans, shifts and rewrites the segment table, holds totals
// depends on fsa_pkg (seg_t, req_t, res_t, bstate_t, status codes)
module fsa_back #(
  parameter int MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = fsa_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fsa_pkg::LENW-1:0]       cfg_wr_data,
  input  logic                           q_vld,
  input  fsa_pkg::req_t                  q_data,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fsa_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW = fsa_pkg::LENW;
  localparam int BW = fsa_pkg::BASEW;
  localparam logic [33:0] LIMIT = 34'd1 << ADDR_BITS;

  fsa_pkg::seg_t    mem [MAX_SEGMENTS];
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_wa, mem_ra;
  fsa_pkg::seg_t    mem_wd;
  fsa_pkg::seg_t    mem_rd_r;

  fsa_pkg::bstate_t state_r, state_nxt;
  fsa_pkg::req_t    req_r;
  logic [LW-1:0]    mem_bytes_r;
  logic [LW-1:0]    free_r, used_r;
  logic [CW-1:0]    n_r, holes_r, owners_r;
  logic [CW-1:0]    ptr_r, sh_cnt_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  logic             dup_r, fit_vld_r, want_next_r, next_vld_r, sh_up_r, fix2_en_r;
  logic [IW-1:0]    fit_idx_r, fix1_idx_r, fix2_idx_r;
  fsa_pkg::seg_t    fit_ent_r, last_r, prev_r, next_r, fix1_r, fix2_r;
  logic [1:0]       sh_off_r;
  fsa_pkg::status_t st_r;
  logic [BW-1:0]    start_r;
  logic             out_vld_r;
  fsa_pkg::res_t    out_r;

  logic             cfg_take;
  logic [LW-1:0]    cfg_val;
  logic             is_alloc, scan_issue, scan_end, sh_issue, out_free;
  logic             prev_hole, next_hole;
  logic [1:0]       merge_cnt;
  logic [IW-1:0]    tgt_idx;
  logic [LW-1:0]    merged_len;

  assign is_alloc  = (req_r.kind == fsa_pkg::KIND_ALLOC);
  assign cfg_take  = cfg_wr_en && (cfg_wr_data != '0);
  assign cfg_val   = ({17'd0, cfg_wr_data} > LIMIT) ? LIMIT[LW-1:0] : cfg_wr_data;
  assign out_free  = !out_vld_r || out_tready;
  assign scan_issue = (ptr_r < n_r);
  assign scan_end  = !scan_issue && !rd_vld_r;
  assign sh_issue  = (sh_cnt_r != '0);

  // free-side merge decision
  assign prev_hole  = (fit_idx_r != '0) && prev_r.is_free;
  assign next_hole  = next_vld_r && next_r.is_free;
  assign merge_cnt  = {1'b0, prev_hole} + {1'b0, next_hole};
  assign tgt_idx    = fit_idx_r - IW'(prev_hole);
  assign merged_len = fit_ent_r.len + (prev_hole ? prev_r.len : '0)
                      + (next_hole ? next_r.len : '0);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_r <= mem[mem_ra];
  end

  // next state and table port control
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = fix1_r;
    mem_re    = 1'b0;
    mem_ra    = ptr_r[IW-1:0];
    unique case (state_r)
      fsa_pkg::B_INIT: begin
        mem_we         = 1'b1;
        mem_wd.owner   = '0;
        mem_wd.len     = mem_bytes_r;
        mem_wd.base    = '0;
        mem_wd.is_free = 1'b1;
        state_nxt      = fsa_pkg::B_IDLE;
      end
      fsa_pkg::B_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          if (q_data.kind == fsa_pkg::KIND_ZERO) begin
            state_nxt = fsa_pkg::B_DONE;
          end else if (q_data.kind == fsa_pkg::KIND_ALLOC && q_data.size > free_r) begin
            state_nxt = fsa_pkg::B_DONE;
          end else begin
            state_nxt = fsa_pkg::B_SCAN;
          end
        end
      end
      fsa_pkg::B_SCAN: begin
        mem_re = scan_issue;
        if (scan_end) state_nxt = fsa_pkg::B_DECIDE;
      end
      fsa_pkg::B_DECIDE: begin
        if (is_alloc) begin
          if (dup_r || !fit_vld_r) begin
            state_nxt = fsa_pkg::B_DONE;
          end else if (fit_ent_r.len != req_r.size && n_r >= CW'(MAX_SEGMENTS)) begin
            state_nxt = fsa_pkg::B_DONE;
          end else begin
            state_nxt = fsa_pkg::B_SHIFT;
          end
        end else begin
          state_nxt = fit_vld_r ? fsa_pkg::B_SHIFT : fsa_pkg::B_DONE;
        end
      end
      fsa_pkg::B_SHIFT: begin
        mem_re = sh_issue;
        mem_we = rd_vld_r;
        mem_wd = mem_rd_r;
        mem_wa = sh_up_r ? rd_idx_r + IW'(1) : rd_idx_r - IW'(sh_off_r);
        if (!sh_issue && !rd_vld_r) state_nxt = fsa_pkg::B_FIX1;
      end
      fsa_pkg::B_FIX1: begin
        mem_we    = 1'b1;
        mem_wa    = fix1_idx_r;
        mem_wd    = fix1_r;
        state_nxt = fix2_en_r ? fsa_pkg::B_FIX2 : fsa_pkg::B_DONE;
      end
      fsa_pkg::B_FIX2: begin
        mem_we    = 1'b1;
        mem_wa    = fix2_idx_r;
        mem_wd    = fix2_r;
        state_nxt = fsa_pkg::B_DONE;
      end
      fsa_pkg::B_DONE: begin
        if (out_free) state_nxt = fsa_pkg::B_IDLE;
      end
      default: state_nxt = fsa_pkg::B_INIT;
    endcase
    if (cfg_take) state_nxt = fsa_pkg::B_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsa_pkg::B_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // totals and table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r <= fsa_pkg::MEM_BYTES_RST;
      n_r         <= CW'(1);
      free_r      <= fsa_pkg::MEM_BYTES_RST;
      used_r      <= '0;
      holes_r     <= CW'(1);
      owners_r    <= '0;
    end else if (cfg_take) begin
      mem_bytes_r <= cfg_val;
    end else if (state_r == fsa_pkg::B_INIT) begin
      n_r      <= CW'(1);
      free_r   <= mem_bytes_r;
      used_r   <= '0;
      holes_r  <= CW'(1);
      owners_r <= '0;
    end else if (state_r == fsa_pkg::B_DECIDE && state_nxt == fsa_pkg::B_SHIFT) begin
      if (is_alloc) begin
        free_r   <= free_r - req_r.size;
        used_r   <= used_r + req_r.size;
        owners_r <= owners_r + CW'(1);
        if (fit_ent_r.len == req_r.size) begin
          holes_r <= holes_r - CW'(1);
        end else begin
          n_r <= n_r + CW'(1);
        end
      end else begin
        free_r   <= free_r + fit_ent_r.len;
        used_r   <= used_r - fit_ent_r.len;
        owners_r <= owners_r - CW'(1);
        holes_r  <= holes_r + CW'(1) - CW'(merge_cnt);
        n_r      <= n_r - CW'(merge_cnt);
      end
    end
  end

  // read pipeline and scan / shift control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= mem_ra;
    unique case (state_r)
      fsa_pkg::B_IDLE: begin
        req_r       <= q_data;
        ptr_r       <= '0;
        dup_r       <= 1'b0;
        fit_vld_r   <= 1'b0;
        want_next_r <= 1'b0;
        next_vld_r  <= 1'b0;
        start_r     <= '0;
        if (q_data.kind == fsa_pkg::KIND_ZERO) begin
          st_r <= fsa_pkg::ST_ZERO;
        end else begin
          st_r <= fsa_pkg::ST_NOSPACE;
        end
      end
      fsa_pkg::B_SCAN: begin
        if (scan_issue) ptr_r <= ptr_r + CW'(1);
        if (rd_vld_r) begin
          last_r <= mem_rd_r;
          if (is_alloc) begin
            if (!mem_rd_r.is_free && mem_rd_r.owner == req_r.id) dup_r <= 1'b1;
            if (!fit_vld_r && mem_rd_r.is_free && mem_rd_r.len >= req_r.size) begin
              fit_vld_r <= 1'b1;
              fit_idx_r <= rd_idx_r;
              fit_ent_r <= mem_rd_r;
            end
          end else begin
            if (want_next_r) begin
              next_r      <= mem_rd_r;
              next_vld_r  <= 1'b1;
              want_next_r <= 1'b0;
            end
            if (!fit_vld_r && !mem_rd_r.is_free && mem_rd_r.owner == req_r.id) begin
              fit_vld_r   <= 1'b1;
              fit_idx_r   <= rd_idx_r;
              fit_ent_r   <= mem_rd_r;
              prev_r      <= last_r;
              want_next_r <= 1'b1;
            end
          end
        end
      end
      fsa_pkg::B_DECIDE: begin
        start_r   <= '0;
        fix2_en_r <= 1'b0;
        if (is_alloc) begin
          sh_up_r  <= 1'b1;
          sh_off_r <= 2'd1;
          ptr_r    <= n_r - CW'(1);
          sh_cnt_r <= '0;
          if (dup_r) begin
            st_r <= fsa_pkg::ST_EXISTS;
          end else if (!fit_vld_r) begin
            st_r <= fsa_pkg::ST_FRAG;
          end else if (fit_ent_r.len == req_r.size) begin
            st_r         <= fsa_pkg::ST_OK;
            start_r      <= fit_ent_r.base;
            fix1_idx_r   <= fit_idx_r;
            fix1_r.owner <= req_r.id;
            fix1_r.len   <= req_r.size;
            fix1_r.base  <= fit_ent_r.base;
            fix1_r.is_free <= 1'b0;
          end else if (n_r >= CW'(MAX_SEGMENTS)) begin
            st_r <= fsa_pkg::ST_FULL;
          end else begin
            // split: move the tail up one slot, then write hole and owned part
            st_r           <= fsa_pkg::ST_OK;
            start_r        <= fit_ent_r.base;
            sh_cnt_r       <= n_r - CW'(1) - CW'(fit_idx_r);
            fix1_idx_r     <= fit_idx_r + IW'(1);
            fix1_r.owner   <= '0;
            fix1_r.len     <= fit_ent_r.len - req_r.size;
            fix1_r.base    <= fit_ent_r.base + req_r.size[BW-1:0];
            fix1_r.is_free <= 1'b1;
            fix2_en_r      <= 1'b1;
            fix2_idx_r     <= fit_idx_r;
            fix2_r.owner   <= req_r.id;
            fix2_r.len     <= req_r.size;
            fix2_r.base    <= fit_ent_r.base;
            fix2_r.is_free <= 1'b0;
          end
        end else begin
          // free: merged hole lands at tgt_idx, the tail moves down by merge_cnt
          sh_up_r        <= 1'b0;
          sh_off_r       <= merge_cnt;
          ptr_r          <= CW'(tgt_idx) + CW'(merge_cnt) + CW'(1);
          sh_cnt_r       <= n_r - CW'(tgt_idx) - CW'(merge_cnt) - CW'(1);
          fix1_idx_r     <= tgt_idx;
          fix1_r.owner   <= '0;
          fix1_r.len     <= merged_len;
          fix1_r.base    <= prev_hole ? prev_r.base : fit_ent_r.base;
          fix1_r.is_free <= 1'b1;
          if (fit_vld_r) begin
            st_r    <= fsa_pkg::ST_OK;
            start_r <= fit_ent_r.base;
          end else begin
            st_r <= fsa_pkg::ST_ABSENT;
          end
        end
      end
      fsa_pkg::B_SHIFT: begin
        if (sh_issue) begin
          sh_cnt_r <= sh_cnt_r - CW'(1);
          ptr_r    <= sh_up_r ? ptr_r - CW'(1) : ptr_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == fsa_pkg::B_DONE && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fsa_pkg::B_DONE && out_free) begin
      out_r.status <= st_r;
      out_r.start  <= start_r;
      out_r.free   <= free_r;
      out_r.used   <= used_r;
      out_r.holes  <= fsa_pkg::CNTOW'(holes_r);
      out_r.owners <= fsa_pkg::CNTOW'(owners_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(fsa_pkg::OUT_DATA_W - fsa_pkg::RES_W){1'b0}}, out_r};

endmodule

>>> rtl/first_fit_segment_allocator.sv
// first-fit segment allocator: a request refused at intake (size zero or above the free
// total) skips the table scan; any other request is scanned over the table entries in use,
// and an accepted one may shift the tail entries and rewrites one entry, two for a split;
// one request is in the table engine at a time, paced by the one-entry-per-cycle scan and
// shift; queue and result register decouple intake and output; reset (rst_n, synchronous)
// and nonzero size writes rebuild the table
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = fsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = fsa_pkg::ADDR_BITS_DEF,
  parameter int ID_BITS      = fsa_pkg::ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: memory_bytes
  input  logic                           cfg_wr_en,
  input  logic [fsa_pkg::LENW-1:0]       cfg_wr_data,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fsa_pkg::IN_DATA_W-1:0]  in_tdata,    // owner_id[15:0], req_size[32:16]
  input  logic                           in_tuser,    // req_type: 0 allocate, 1 free
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fsa_pkg::OUT_DATA_W-1:0] out_tdata    // status[2:0], seg_start[18:3],
                                                      // free_total[35:19], used_total[52:36],
                                                      // hole_count[58:53], owner_count[64:59]
);

  // front to queue
  logic          push;
  fsa_pkg::req_t push_data;
  logic          q_full;
  // queue to back
  logic          q_pop;
  logic          q_vld;
  fsa_pkg::req_t q_data;

  // front: unpacks and tags each transfer (allocate, free, or zero-size allocate)
  fsa_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // short queue so intake keeps flowing while the table engine works
  fsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_vld),
    .pop_data  (q_data)
  );

  // back: scans for duplicate id / first fit (or the owner's entry on a free), then shifts and rewrites entries
  fsa_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_vld       (q_vld),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

>>> sim/tb_first_fit_segment_allocator.sv
// testbench for the first-fit segment allocator: directed and random requests
// checked against a behavioral table model; depends on rtl/fsa_pkg.sv and the dut
module tb_first_fit_segment_allocator;

  localparam int SEGS = fsa_pkg::MAX_SEGMENTS_DEF;
  localparam int SETTLE = 2 * SEGS + 20;  // worst-case engine latency plus margin

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [fsa_pkg::LENW-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fsa_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fsa_pkg::OUT_DATA_W-1:0] out_tdata;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  first_fit_segment_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predicted segment table
  logic [fsa_pkg::BASEW-1:0] tbl_base [SEGS];
  logic [fsa_pkg::LENW-1:0] tbl_len [SEGS];
  logic [fsa_pkg::IDW-1:0] tbl_owner [SEGS];
  logic tbl_hole [SEGS];
  int tbl_n;
  logic [fsa_pkg::LENW-1:0] mem_size, bytes_free, bytes_used;
  int n_holes, n_owners;

  fsa_pkg::res_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int n_alloc_ok = 0, n_free_ok = 0, n_rejects = 0;
  bit out_stall_en = 1'b1;

  task automatic table_rebuild();
    for (int k = 0; k < SEGS; k++) begin
      tbl_base[k] = '0; tbl_len[k] = '0; tbl_owner[k] = '0; tbl_hole[k] = 1'b0;
    end
    tbl_len[0] = mem_size;
    tbl_hole[0] = 1'b1;
    tbl_n = 1;
    bytes_free = mem_size;
    bytes_used = '0;
    n_holes = 1;
    n_owners = 0;
  endtask

  task automatic entry_drop(int k);
    for (int j = k; j + 1 < tbl_n; j++) begin
      tbl_base[j] = tbl_base[j+1]; tbl_len[j] = tbl_len[j+1];
      tbl_owner[j] = tbl_owner[j+1]; tbl_hole[j] = tbl_hole[j+1];
    end
    tbl_n--;
  endtask

  function automatic int find_owner(logic [fsa_pkg::IDW-1:0] id);
    for (int k = 0; k < tbl_n; k++)
      if (!tbl_hole[k] && tbl_owner[k] == id) return k;
    return -1;
  endfunction

  task automatic alloc_predict(logic [fsa_pkg::IDW-1:0] id, logic [fsa_pkg::LENW-1:0] size,
                               output fsa_pkg::status_t st,
                               output logic [fsa_pkg::BASEW-1:0] start);
    int hit;
    st = fsa_pkg::ST_FRAG;
    start = '0;
    hit = -1;
    if (size == 0) st = fsa_pkg::ST_ZERO;
    else if (size > bytes_free) st = fsa_pkg::ST_NOSPACE;
    else if (find_owner(id) >= 0) st = fsa_pkg::ST_EXISTS;
    else begin
      for (int k = 0; k < tbl_n; k++)
        if (hit < 0 && tbl_hole[k] && tbl_len[k] >= size) hit = k;
      if (hit >= 0) begin
        if (tbl_len[hit] == size) begin
          n_holes--;
          st = fsa_pkg::ST_OK;
        end else if (tbl_n >= SEGS) begin
          st = fsa_pkg::ST_FULL;
        end else begin
          for (int j = tbl_n; j > hit + 1; j--) begin
            tbl_base[j] = tbl_base[j-1]; tbl_len[j] = tbl_len[j-1];
            tbl_owner[j] = tbl_owner[j-1]; tbl_hole[j] = tbl_hole[j-1];
          end
          tbl_base[hit+1] = tbl_base[hit] + size[fsa_pkg::BASEW-1:0];
          tbl_len[hit+1] = tbl_len[hit] - size;
          tbl_owner[hit+1] = '0;
          tbl_hole[hit+1] = 1'b1;
          tbl_len[hit] = size;
          tbl_n++;
          st = fsa_pkg::ST_OK;
        end
        if (st == fsa_pkg::ST_OK) begin
          tbl_hole[hit] = 1'b0;
          tbl_owner[hit] = id;
          bytes_free -= size;
          bytes_used += size;
          n_owners++;
          start = tbl_base[hit];
        end
      end
    end
  endtask

  task automatic free_predict(logic [fsa_pkg::IDW-1:0] id, output fsa_pkg::status_t st,
                              output logic [fsa_pkg::BASEW-1:0] start);
    int k;
    k = find_owner(id);
    start = '0;
    if (k < 0) begin
      st = fsa_pkg::ST_ABSENT;
    end else begin
      st = fsa_pkg::ST_OK;
      start = tbl_base[k];
      tbl_hole[k] = 1'b1;
      tbl_owner[k] = '0;
      bytes_free += tbl_len[k];
      bytes_used -= tbl_len[k];
      n_holes++;
      n_owners--;
      // merge with the hole after, then the one before
      if (k + 1 < tbl_n && tbl_hole[k+1]) begin
        tbl_len[k] += tbl_len[k+1];
        entry_drop(k + 1);
        n_holes--;
      end
      if (k > 0 && tbl_hole[k-1]) begin
        tbl_len[k-1] += tbl_len[k];
        entry_drop(k);
        n_holes--;
      end
    end
  endtask

  // register write while idle; mirrors saturation and the ignored zero write
  task automatic size_write(logic [fsa_pkg::LENW-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (v != 0) begin
      mem_size = (v > 17'd65536) ? 17'd65536 : v;
      table_rebuild();
    end
    repeat (3) @(posedge clk);
  endtask

  // one request transfer; prediction is queued at acceptance
  task automatic send_req(bit is_free, logic [fsa_pkg::IDW-1:0] id,
                          logic [fsa_pkg::LENW-1:0] size, bit no_gap = 1'b0);
    fsa_pkg::res_t r;
    fsa_pkg::status_t st;
    logic [fsa_pkg::BASEW-1:0] start;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_free;
    in_tdata <= {7'b0, size, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (is_free) free_predict(id, st, start);
    else alloc_predict(id, size, st, start);
    if (st == fsa_pkg::ST_OK) begin
      if (is_free) n_free_ok++; else n_alloc_ok++;
    end else n_rejects++;
    r.status = st; r.start = start; r.free = bytes_free; r.used = bytes_used;
    r.holes = n_holes[fsa_pkg::CNTOW-1:0]; r.owners = n_owners[fsa_pkg::CNTOW-1:0];
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // result side: random stall per transfer, with stretches of none
  initial begin
    int wait_n;
    forever begin
      wait_n = out_stall_en ? $urandom_range(0, 7) : 0;
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    fsa_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = fsa_pkg::res_t'(out_tdata[fsa_pkg::RES_W-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d start=%0d free=%0d used=%0d holes=%0d own=%0d",
              want.status, want.start, want.free, want.used, want.holes, want.owners);
            $display("          got st=%0d start=%0d free=%0d used=%0d holes=%0d own=%0d",
              got.status, got.start, got.free, got.used, got.holes, got.owners);
          end
        end
      end
    end
  end

  // zero, no-space, existing and absent statuses plus split, exact fit and merges with the hole before and after
  task automatic test_directed();
    send_req(1'b0, 16'd1, 17'd0);          // size zero
    send_req(1'b0, 16'd1, 17'd2000);       // more than free
    send_req(1'b0, 16'd1, 17'd100);        // split
    send_req(1'b0, 16'd1, 17'd10);         // id already present
    send_req(1'b0, 16'hFFFF, 17'd200);
    send_req(1'b0, 16'd0, 17'd300);
    send_req(1'b1, 16'h1234, 17'd0);       // absent id
    send_req(1'b1, 16'hFFFF, 17'h1FFFF);   // free, hole between owners
    send_req(1'b0, 16'd7, 17'd400);        // larger than hole 200
    send_req(1'b0, 16'd8, 17'd24);         // exact fit at the end
    send_req(1'b0, 16'd9, 17'd250);        // more than free: only a 200 hole remains
    send_req(1'b0, 16'd5, 17'd200);        // exact fit of the middle hole
    send_req(1'b1, 16'd5, 17'd0);
    send_req(1'b1, 16'd0, 17'd0);          // merge with hole before
    send_req(1'b1, 16'd1, 17'd0);          // merge with hole after
    send_req(1'b1, 16'd7, 17'd0);
    send_req(1'b1, 16'd8, 17'd0);
    drain_results();
  endtask

  // register extremes: minimum, saturation, ignored zero, full size
  task automatic test_size_extremes();
    size_write(17'd1);
    send_req(1'b0, 16'd3, 17'd1);
    send_req(1'b0, 16'd4, 17'd1);
    drain_results();
    size_write(17'h1FFFF);                 // saturates to 65536
    send_req(1'b0, 16'hAAAA, 17'd65536);
    send_req(1'b1, 16'hAAAA, 17'd0);
    send_req(1'b0, 16'h5555, 17'd65535);
    drain_results();
    size_write(17'd0);                     // ignored, table kept
    send_req(1'b0, 16'h0F0F, 17'd1);
    send_req(1'b0, 16'h0F10, 17'd1);
    drain_results();
  endtask

  // fill the table with small splits until it reports full
  task automatic test_table_full();
    size_write(17'd1000);
    for (int k = 0; k < 33; k++) send_req(1'b0, 16'(100 + k), 17'd2);
    send_req(1'b1, 16'd105, 17'd0);
    send_req(1'b0, 16'd200, 17'd1);        // hole of 2 fits, table full
    send_req(1'b0, 16'd201, 17'd2);        // exact fit still allowed
    drain_results();
  endtask

  // random traffic mostly on live ids
  task automatic test_random(int count, logic [fsa_pkg::LENW-1:0] msize);
    logic [fsa_pkg::IDW-1:0] id;
    logic [fsa_pkg::LENW-1:0] size;
    int pick;
    size_write(msize);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      id = (pick < 90) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      if (pick < 5) size = 17'($urandom);
      else if (pick < 8) size = '0;
      else size = 17'($urandom_range(1, msize / 8 + 1));
      send_req($urandom_range(0, 99) < 40, id, size, k % 50 < 10);
      if (k == count / 2) begin
        // sender holds off until the pipeline is empty
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    drain_results();
  endtask

  initial begin
    mem_size = fsa_pkg::MEM_BYTES_RST;
    table_rebuild();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_directed();
    test_size_extremes();
    test_table_full();
    test_random(180, 17'd1024);
    out_stall_en = 1'b0;
    test_random(120, 17'd300);
    out_stall_en = 1'b1;
    test_random(200, 17'd65536);
    $display("covered %0d good allocates, %0d good frees, %0d rejected requests",
             n_alloc_ok, n_free_ok, n_rejects);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
